### rtl/core/wdirq_pkg.sv
// types, constants and helper functions shared by the watchdog irq owner tracker
// no dependencies
`default_nettype none

package wdirq_pkg;

  localparam int unsigned NUM_CORES = 8;
  localparam int unsigned CORE_W    = 5;
  localparam int unsigned CNT_W     = CORE_W + 1;
  localparam int unsigned AFF_W     = 64;
  localparam int unsigned IDX_W     = (NUM_CORES > 1) ? $clog2(NUM_CORES) : 1;

  localparam int unsigned IN_TDATA_W  = 72;
  localparam int unsigned IN_TUSER_W  = 2;
  localparam int unsigned OUT_TDATA_W = 80;

  typedef enum logic [1:0] {
    OP_WAKEUP  = 2'd0,
    OP_HOTPLUG = 2'd1,
    OP_SUSPEND = 2'd2,
    OP_NOP     = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ERR_NONE        = 2'd0,
    ERR_NO_IRQ_CORE = 2'd1,
    ERR_NO_AFFINITY = 2'd2
  } err_e;

  typedef struct packed {
    op_e               op;
    logic [CORE_W-1:0] core;
    logic [AFF_W-1:0]  aff;
  } event_t;

  typedef struct packed {
    logic              route_changed;
    logic [CORE_W-1:0] target_core;
    logic [AFF_W-1:0]  target_affinity;
    logic              owner_valid;
    err_e              error;
  } result_t;

  // priority encoder, lowest set bit wins; zero when mask is empty
  function automatic logic [IDX_W-1:0] lowest_bit(input logic [NUM_CORES-1:0] m);
    logic [IDX_W-1:0] r;
    r = '0;
    for (int i = NUM_CORES - 1; i >= 0; i--) begin
      if (m[i]) begin
        r = IDX_W'(i);
      end
    end
    return r;
  endfunction

  function automatic logic several_bits(input logic [NUM_CORES-1:0] m);
    return (m & (m - 1'b1)) != '0;
  endfunction

endpackage

`default_nettype wire

### rtl/core/watchdog_irq_owner_tracker.sv
// watchdog irq owner tracker top level; depends on wdirq_pkg, wdirq_in_stage, wdirq_tracker
// an accepted event is held in the wdirq_in_stage input register, then registered as a result
// in wdirq_tracker, from where it leaves when the output takes it
// throughput: one event per cycle; while the output stalls the input register holds one
// more word, then s_axis_tready_o drops until the result word is taken
// reset clears masks, owner and affinity-known bits; the affinity table is not reset
`default_nettype none

module watchdog_irq_owner_tracker (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  s_axis_tvalid_i,
  output logic                                       s_axis_tready_o,
  // core [4:0], core_affinity [68:5], zero fill above
  input  wire logic [wdirq_pkg::IN_TDATA_W-1:0]      s_axis_tdata_i,
  // operation [1:0]
  input  wire logic [wdirq_pkg::IN_TUSER_W-1:0]      s_axis_tuser_i,
  output logic                                       m_axis_tvalid_o,
  input  wire logic                                  m_axis_tready_i,
  // route_changed [0], target_core [5:1], target_affinity [69:6],
  // owner_valid [70], error [72:71], zero fill above
  output logic [wdirq_pkg::OUT_TDATA_W-1:0]          m_axis_tdata_o
);
  import wdirq_pkg::*;

  event_t  in_evt;
  event_t  evt;
  logic    evt_valid;
  logic    evt_take;
  result_t res;

  assign in_evt.op   = op_e'(s_axis_tuser_i);
  assign in_evt.core = s_axis_tdata_i[CORE_W-1:0];
  assign in_evt.aff  = s_axis_tdata_i[CORE_W+AFF_W-1:CORE_W];

  wdirq_in_stage u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid_i),
    .ready_o (s_axis_tready_o),
    .evt_i   (in_evt),
    .valid_o (evt_valid),
    .take_i  (evt_take),
    .evt_o   (evt)
  );

  wdirq_tracker u_tracker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .evt_valid_i (evt_valid),
    .evt_i       (evt),
    .evt_take_o  (evt_take),
    .res_valid_o (m_axis_tvalid_o),
    .res_ready_i (m_axis_tready_i),
    .res_o       (res)
  );

  assign m_axis_tdata_o = {7'd0, res.error, res.owner_valid, res.target_affinity,
                           res.target_core, res.route_changed};

endmodule

`default_nettype wire

### rtl/core/wdirq_in_stage.sv
// input register for power events, accepts a new word whenever it is empty
// or being drained in the same cycle; depends on wdirq_pkg
`default_nettype none

module wdirq_in_stage (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            valid_i,
  output logic                 ready_o,
  input  wire wdirq_pkg::event_t evt_i,
  output logic                 valid_o,
  input  wire logic            take_i,
  output wdirq_pkg::event_t    evt_o
);
  import wdirq_pkg::*;

  logic   valid_q, valid_d;
  event_t evt_q, evt_d;

  assign ready_o = !valid_q || take_i;

  always_comb begin
    valid_d = valid_q;
    evt_d   = evt_q;
    if (ready_o) begin
      valid_d = valid_i;
      if (valid_i) begin
        evt_d = evt_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    evt_q <= evt_d;
  end

  assign valid_o = valid_q;
  assign evt_o   = evt_q;

endmodule

`default_nettype wire

### rtl/core/wdirq_tracker.sv
// owner tracking state, next-state logic and result register
// depends on wdirq_pkg
`default_nettype none

module wdirq_tracker (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              evt_valid_i,
  input  wire wdirq_pkg::event_t evt_i,
  output logic                   evt_take_o,
  output logic                   res_valid_o,
  input  wire logic              res_ready_i,
  output wdirq_pkg::result_t     res_o
);
  import wdirq_pkg::*;

  logic [NUM_CORES-1:0] online_q, online_d;
  logic [NUM_CORES-1:0] irq_q, irq_d;
  logic [NUM_CORES-1:0] known_q, known_d;
  logic [CORE_W-1:0]    owner_q, owner_d;
  logic                 present_q, present_d;
  logic [AFF_W-1:0]     owner_aff_q, owner_aff_d;
  logic [AFF_W-1:0]     aff_tbl_q [NUM_CORES];

  logic                 res_valid_q, res_valid_d;
  result_t              res_q, res_d;

  logic                 advance;
  logic                 in_range;
  logic [IDX_W-1:0]     idx;
  logic [NUM_CORES-1:0] bit_oh;
  logic                 is_owner;
  logic                 have_tgt;
  logic [IDX_W-1:0]     tgt;
  err_e                 err;
  logic                 changed;
  logic                 tbl_wr;

  assign advance    = evt_valid_i && (!res_valid_q || res_ready_i);
  assign evt_take_o = advance;

  always_comb begin
    in_range  = {1'b0, evt_i.core} < CNT_W'(NUM_CORES);
    idx       = evt_i.core[IDX_W-1:0];
    bit_oh    = '0;
    bit_oh[idx] = 1'b1;
    is_owner  = present_q && (owner_q == evt_i.core);

    online_d    = online_q;
    irq_d       = irq_q;
    known_d     = known_q;
    owner_d     = owner_q;
    present_d   = present_q;
    owner_aff_d = owner_aff_q;
    have_tgt    = 1'b0;
    tgt         = '0;
    err         = ERR_NONE;
    changed     = 1'b0;
    tbl_wr      = 1'b0;

    if (in_range) begin
      tbl_wr  = !known_q[idx];
      known_d = known_q | bit_oh;

      case (evt_i.op)
        OP_WAKEUP: begin
          irq_d    = irq_q | bit_oh;
          online_d = online_q | bit_oh;
          if (!present_q || !online_d[owner_q[IDX_W-1:0]]) begin
            have_tgt = 1'b1;
            tgt      = idx;
          end
        end
        OP_HOTPLUG: begin
          irq_d    = irq_q & ~bit_oh;
          online_d = online_q & ~bit_oh;
          if (is_owner) begin
            if (several_bits(online_q)) begin
              have_tgt = 1'b1;
              tgt      = lowest_bit(online_d);
            end else if (irq_d == '0) begin
              err = ERR_NO_IRQ_CORE;
            end else begin
              have_tgt = 1'b1;
              tgt      = lowest_bit(irq_d);
            end
          end
        end
        OP_SUSPEND: begin
          online_d = online_q & ~bit_oh;
          if (is_owner && several_bits(online_q)) begin
            have_tgt = 1'b1;
            tgt      = lowest_bit(online_d);
          end
        end
        default: begin
        end
      endcase

      if (have_tgt) begin
        if (!known_d[tgt]) begin
          err = ERR_NO_AFFINITY;
        end else begin
          owner_d   = CORE_W'(tgt);
          present_d = 1'b1;
          changed   = 1'b1;
          // the target may be the core whose affinity is captured right now
          owner_aff_d = (tgt == idx && tbl_wr) ? evt_i.aff : aff_tbl_q[tgt];
        end
      end
    end

    res_d.route_changed   = changed;
    res_d.target_core     = present_d ? owner_d : '0;
    res_d.target_affinity = present_d ? owner_aff_d : '0;
    res_d.owner_valid     = present_d;
    res_d.error           = err;

    res_valid_d = res_valid_q;
    if (advance) begin
      res_valid_d = 1'b1;
    end else if (res_ready_i) begin
      res_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      online_q    <= '0;
      irq_q       <= '0;
      known_q     <= '0;
      owner_q     <= '0;
      present_q   <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= res_valid_d;
      if (advance) begin
        online_q  <= online_d;
        irq_q     <= irq_d;
        known_q   <= known_d;
        owner_q   <= owner_d;
        present_q <= present_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      owner_aff_q <= owner_aff_d;
      res_q       <= res_d;
      if (tbl_wr) begin
        aff_tbl_q[idx] <= evt_i.aff;
      end
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

### rtl/core/wdirq_checker.sv
// port-level checks for the watchdog irq owner tracker, bound to the top level
// depends on wdirq_pkg
`default_nettype none

module wdirq_checker (
  input wire logic                                  clk_i,
  input wire logic                                  rst_ni,
  input wire logic                                  s_axis_tvalid_i,
  input wire logic                                  s_axis_tready_o,
  input wire logic [wdirq_pkg::IN_TDATA_W-1:0]      s_axis_tdata_i,
  input wire logic [wdirq_pkg::IN_TUSER_W-1:0]      s_axis_tuser_i,
  input wire logic                                  m_axis_tvalid_o,
  input wire logic                                  m_axis_tready_i,
  input wire logic [wdirq_pkg::OUT_TDATA_W-1:0]     m_axis_tdata_o
);
  import wdirq_pkg::*;

  // a word waiting at the output stays until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("output word dropped while stalled");

  a_err_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[72:71] != 2'd3)
    else $error("undefined error code");

  // a reroute always leaves a valid owner and never carries an error
  a_route_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[0] |->
      m_axis_tdata_o[70] && m_axis_tdata_o[72:71] == 2'd0)
    else $error("reroute without owner or with error");

  a_no_owner_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tdata_o[70] |->
      m_axis_tdata_o[5:1] == 5'd0 && m_axis_tdata_o[69:6] == 64'd0)
    else $error("target reported with no owner");

endmodule

bind watchdog_irq_owner_tracker wdirq_checker u_wdirq_checker (.*);

`default_nettype wire
